### design/wspa_pkg.sv
// ----------------------------------------------------------------------------
// wspa_pkg: shared definitions for the wheel speed period averager
// Widths, reset values, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package wspa_pkg;

  // Field widths
  localparam int SPEED_W   = 25;
  localparam int ELAPSED_W = 16;
  localparam int TICK_W    = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIST    = 1'b0,
    REG_TIMEOUT = 1'b1
  } cfg_reg_e;

  localparam logic [SPEED_W-1:0]   DIST_RESET    = 25'd20588724;
  localparam logic [ELAPSED_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;

  // Speed history ring
  localparam int RING_DEPTH = 10;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = SPEED_W + $clog2(RING_DEPTH);

  // Ring average: sum times a rounded-up scaled reciprocal of the depth.
  // The extra clog2(depth) bits of scale keep the floor exact for any sum.
  localparam int              AVG_SHIFT      = SUM_W + $clog2(RING_DEPTH);
  localparam int              RECIP_W        = SUM_W + 1;
  localparam int              PROD_W         = SUM_W + RECIP_W;
  localparam longint unsigned AVG_RECIP_FULL =
      ((64'd1 << AVG_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
  localparam logic [RECIP_W-1:0] AVG_RECIP   = RECIP_W'(AVG_RECIP_FULL);

  // Serial divider: distance by elapsed time
  localparam int DIV_W     = SPEED_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic in_load;        // capture the accepted beat
    logic tick_do;        // advance elapsed time, check timeout
    logic div_spd_start;  // distance / elapsed
    logic ring_wr;        // store quotient in the ring, clear elapsed
    logic sum_start;      // begin walking the ring
    logic div_avg_start;  // ring sum / depth
    logic avg_load;       // quotient becomes the current speed
    logic out_load;       // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_tick;
    logic is_falling;
    logic elapsed_zero;
    logic div_busy;
    logic sum_done;
  } dp_status_t;

endpackage

### design/wspa_if.sv
// ----------------------------------------------------------------------------
// wspa_if: valid/ready channels of the wheel speed period averager
// Input event channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface wspa_in_if;
  import wspa_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic              pin_level;
  logic [TICK_W-1:0] tick_ms;

  modport source (output valid, output operation, output pin_level, output tick_ms,
                  input ready);
  modport sink   (input valid, input operation, input pin_level, input tick_ms,
                  output ready);
endinterface

interface wspa_out_if;
  import wspa_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;
  logic               too_fast;
  logic               stopped;

  modport source (output valid, output speed, output too_fast, output stopped,
                  input ready);
  modport sink   (input valid, input speed, input too_fast, input stopped,
                  output ready);
endinterface

interface wspa_cfg_if;
  import wspa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

### design/wspa_div.sv
// ----------------------------------------------------------------------------
// wspa_div: restoring serial divider
// One quotient bit per cycle; busy while running.
// ----------------------------------------------------------------------------
module wspa_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wspa_pkg::DIV_W-1:0]     dividend_i,
  input  logic [wspa_pkg::ELAPSED_W-1:0] divisor_i,
  output logic                           busy_o,
  output logic [wspa_pkg::DIV_W-1:0]     quotient_o
);
  import wspa_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ELAPSED_W-1:0] rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [ELAPSED_W-1:0] dvs_q;

  logic [ELAPSED_W:0]   trial;
  logic [ELAPSED_W:0]   diff;
  logic                 ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

### design/wspa_datapath.sv
// ----------------------------------------------------------------------------
// wspa_datapath: elapsed timer, speed ring, ring sum and result register
// Holds configuration, runs the divider and walks the ring memory.
// ----------------------------------------------------------------------------
module wspa_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wspa_pkg::ctrl_cmd_t             cmd_i,
  output wspa_pkg::dp_status_t            status_o,
  input  logic                            in_operation_i,
  input  logic                            in_pin_level_i,
  input  logic [wspa_pkg::TICK_W-1:0]     in_tick_ms_i,
  input  logic                            cfg_valid_i,
  input  logic [wspa_pkg::CFG_IDX_W-1:0]  cfg_reg_idx_i,
  input  logic [wspa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [wspa_pkg::SPEED_W-1:0]    speed_o,
  output logic                            too_fast_o,
  output logic                            stopped_o
);
  import wspa_pkg::*;

  // Configuration
  logic [SPEED_W-1:0]   dist_q;
  logic [ELAPSED_W-1:0] timeout_q;

  // Captured beat
  logic                 op_q;
  logic                 pin_q;
  logic [TICK_W-1:0]    tick_q;
  logic                 too_fast_q;

  // Measurement state
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [SPEED_W-1:0]   cur_speed_q;
  logic [SLOT_W-1:0]    slot_q;

  // Ring memory with per-entry valid bits
  logic [SPEED_W-1:0]    ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [SPEED_W-1:0]    rd_data_q;
  logic                  rd_vld_q;
  logic                  sum_busy_q;
  logic [CNT_W-1:0]      sum_cnt_q;
  logic [SUM_W-1:0]      acc_q;
  logic                  rd_issue;
  logic [SLOT_W-1:0]     rd_addr;

  // Ring average
  logic [PROD_W-1:0]     avg_prod;
  logic [SPEED_W-1:0]    avg_q;

  // Result register payload
  logic [SPEED_W-1:0]    out_speed_q;
  logic                  out_too_fast_q;
  logic                  out_stopped_q;

  // Divider hookup
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [ELAPSED_W-1:0]  div_divisor;
  logic                  div_busy;
  logic [DIV_W-1:0]      div_quo;

  logic [ELAPSED_W:0]    elapsed_sum;
  logic [ELAPSED_W-1:0]  elapsed_sat;

  // Saturating elapsed-time add
  always_comb begin
    elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W+1)'(tick_q);
    elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
  end

  // Divider operands: pulse period
  always_comb begin
    div_start    = cmd_i.div_spd_start;
    div_dividend = DIV_W'(dist_q);
    div_divisor  = elapsed_q;
  end

  wspa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q    <= DIST_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_idx_i)
        REG_DIST:    dist_q    <= cfg_wdata_i[SPEED_W-1:0];
        REG_TIMEOUT: timeout_q <= cfg_wdata_i[ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

  // Beat capture; too_fast marks a falling edge that arrives with elapsed at zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q       <= in_operation_i;
      pin_q      <= in_pin_level_i;
      tick_q     <= in_tick_ms_i;
      too_fast_q <= in_operation_i & ~in_pin_level_i & (elapsed_q == '0);
    end
  end

  // Elapsed time, current speed, write slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      cur_speed_q <= '0;
      slot_q      <= '0;
    end else begin
      if (cmd_i.tick_do) begin
        elapsed_q <= elapsed_sat;
        if (elapsed_sat > timeout_q) begin
          cur_speed_q <= '0;
        end
      end
      if (cmd_i.ring_wr) begin
        elapsed_q <= '0;
        slot_q    <= (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
      if (cmd_i.avg_load) begin
        cur_speed_q <= avg_q;
      end
    end
  end

  // Ring write and valid bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_wr) begin
      ring_mem[slot_q] <= div_quo[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
    end else if (cmd_i.ring_wr) begin
      ring_vld_q[slot_q] <= 1'b1;
    end
  end

  // Ring walk: one read per cycle, registered data
  assign rd_issue = sum_busy_q && (sum_cnt_q < CNT_W'(RING_DEPTH));
  assign rd_addr  = sum_cnt_q[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_data_q <= ring_vld_q[rd_addr] ? ring_mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_busy_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      sum_cnt_q  <= '0;
    end else begin
      rd_vld_q <= rd_issue;
      if (cmd_i.sum_start) begin
        sum_busy_q <= 1'b1;
        sum_cnt_q  <= '0;
      end else if (cmd_i.div_avg_start) begin
        sum_busy_q <= 1'b0;
      end else if (rd_issue) begin
        sum_cnt_q <= sum_cnt_q + 1'b1;
      end
    end
  end

  // Accumulate read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_start) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + SUM_W'(rd_data_q);
    end
  end

  // Ring average: sum times scaled reciprocal, one registered multiply
  assign avg_prod = PROD_W'(acc_q) * PROD_W'(AVG_RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_avg_start) begin
      avg_q <= avg_prod[AVG_SHIFT +: SPEED_W];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_speed_q    <= cur_speed_q;
      out_too_fast_q <= too_fast_q;
      out_stopped_q  <= (elapsed_q > timeout_q);
    end
  end

  // Status to the controller
  always_comb begin
    status_o.is_tick      = ~op_q;
    status_o.is_falling   = op_q & ~pin_q;
    status_o.elapsed_zero = (elapsed_q == '0);
    status_o.div_busy     = div_busy;
    status_o.sum_done     = sum_busy_q && (sum_cnt_q == CNT_W'(RING_DEPTH)) && !rd_vld_q;
  end

  assign speed_o    = out_speed_q;
  assign too_fast_o = out_too_fast_q;
  assign stopped_o  = out_stopped_q;

endmodule

### design/wspa_ctrl.sv
// ----------------------------------------------------------------------------
// wspa_ctrl: sequencing state machine
// Accepts one beat; ticks update elapsed time, pin changes run divide (falling
// edge, nonzero elapsed), ring walk and average; then loads the output register.
// ----------------------------------------------------------------------------
module wspa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  wspa_pkg::dp_status_t status_i,
  output wspa_pkg::ctrl_cmd_t  cmd_o
);
  import wspa_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_DIV_SPD = 3'd2;
  localparam logic [2:0] S_SUM     = 3'd3;
  localparam logic [2:0] S_DIV_AVG = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.is_tick) begin
          cmd_o.tick_do = 1'b1;
          state_d       = S_DONE;
        end else if (status_i.is_falling && !status_i.elapsed_zero) begin
          cmd_o.div_spd_start = 1'b1;
          state_d             = S_DIV_SPD;
        end else begin
          cmd_o.sum_start = 1'b1;
          state_d         = S_SUM;
        end
      end
      S_DIV_SPD: begin
        if (!status_i.div_busy) begin
          cmd_o.ring_wr   = 1'b1;
          cmd_o.sum_start = 1'b1;
          state_d         = S_SUM;
        end
      end
      S_SUM: begin
        if (status_i.sum_done) begin
          cmd_o.div_avg_start = 1'b1;
          state_d             = S_DIV_AVG;
        end
      end
      S_DIV_AVG: begin
        if (!status_i.div_busy) begin
          cmd_o.avg_load = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/wheel_speed_period_averager.sv
// ----------------------------------------------------------------------------
// wheel_speed_period_averager: pulse-period wheel speed with moving average
// Timer ticks accumulate elapsed ms; sensor falling edges with nonzero elapsed
// store distance / elapsed in a ring; every pin change re-averages the ring.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  in_i     in   valid / ready   operation, pin_level, tick_ms
//  out_o    out  valid / ready   speed (Q9.16 mm/ms), too_fast, stopped
//  cfg_i    in   valid / ready   reg_idx, wdata (always ready)
//
//  One beat in flight at a time. A tick updates the elapsed time and skips
//  the ring. A pin change walks the ring and re-averages it; a falling edge
//  that stores a speed first runs the serial divider. The divider runs one
//  bit per cycle, the ring is read one entry per cycle and the average is
//  one registered reciprocal multiply.
//  A new beat is accepted while the previous result still waits in out_o.
//  Reset is asynchronous; the ring reads as zero until written.
// ----------------------------------------------------------------------------
module wheel_speed_period_averager (
  input  logic       clk_i,
  input  logic       rst_ni,
  wspa_in_if.sink    in_i,
  wspa_out_if.source out_o,
  wspa_cfg_if.sink   cfg_i
);
  import wspa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  // Controller
  wspa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  wspa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_operation_i (in_i.operation),
    .in_pin_level_i (in_i.pin_level),
    .in_tick_ms_i   (in_i.tick_ms),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_reg_idx_i  (cfg_i.reg_idx),
    .cfg_wdata_i    (cfg_i.wdata),
    .speed_o        (out_o.speed),
    .too_fast_o     (out_o.too_fast),
    .stopped_o      (out_o.stopped)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;

  // Accepted beat blocks the input until its result is staged
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("input accepted while a beat is in flight");

  // Result register is never overwritten while a result waits
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid || out_o.ready))
    else $error("result register overwritten");

  // Divider is only started when idle
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_spd_start || cmd.div_avg_start) |-> !status.div_busy)
    else $error("divider restarted while busy");

  // Sequencing commands other than ring_wr and sum_start are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.in_load, cmd.tick_do, cmd.div_spd_start, cmd.div_avg_start,
              cmd.avg_load, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule

### verif/tb_wheel_speed_period_averager.sv
// ----------------------------------------------------------------------------
// tb_wheel_speed_period_averager: self-checking bench for the speed averager
// Drives timer ticks and sensor pin changes with random gaps and output
// stalls, predicts every result beat from a cycle-free model of the elapsed
// counter, the speed ring and the average, and compares field by field.
// ----------------------------------------------------------------------------
module tb_wheel_speed_period_averager;
  import wspa_pkg::*;

  // Event codes on the input channel
  localparam logic OP_TICK       = 1'b0;
  localparam logic OP_PIN_CHANGE = 1'b1;
  localparam logic LEVEL_FALL    = 1'b0;
  localparam logic LEVEL_RISE    = 1'b1;

  // Wait margin after draining: room for the divider twice plus the ring walk
  localparam int SETTLE_CYCLES = 2 * DIV_W + RING_DEPTH + 8;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               too_fast;
    logic               stopped;
  } speed_result_t;

  // Speed predictor and queue of results still owed by the block
  class speed_scoreboard;
    logic [SPEED_W-1:0]   ring [RING_DEPTH];
    int unsigned          slot;
    logic [ELAPSED_W-1:0] elapsed;
    logic [SPEED_W-1:0]   avg_speed;
    logic [SPEED_W-1:0]   distance;
    logic [ELAPSED_W-1:0] timeout;
    speed_result_t        pending[$];
    int unsigned          errors;
    int unsigned          n_ticks;
    int unsigned          n_pins;
    int unsigned          n_too_fast;
    int unsigned          n_results;
    int unsigned          n_stopped;

    function new();
      foreach (ring[k]) ring[k] = '0;
      slot      = 0;
      elapsed   = '0;
      avg_speed = '0;
      distance  = DIST_RESET;
      timeout   = TIMEOUT_RESET;
      errors    = 0;
      n_ticks   = 0;
      n_pins    = 0;
      n_too_fast = 0;
      n_results = 0;
      n_stopped = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DIST) distance = data[SPEED_W-1:0];
      else timeout = data[ELAPSED_W-1:0];
    endfunction

    // Apply one accepted event beat and queue the result it causes
    function void note_event(logic op, logic level, logic [TICK_W-1:0] tick);
      speed_result_t        want;
      logic [ELAPSED_W:0]   total;
      longint unsigned      sum;
      want.too_fast = 1'b0;
      if (op == OP_TICK) begin
        n_ticks++;
        total   = {1'b0, elapsed} + (ELAPSED_W+1)'(tick);
        elapsed = total[ELAPSED_W] ? ELAPSED_MAX : total[ELAPSED_W-1:0];
        if (elapsed > timeout) avg_speed = '0;
      end else begin
        n_pins++;
        if (level == LEVEL_FALL) begin
          if (elapsed == '0) begin
            want.too_fast = 1'b1;
            n_too_fast++;
          end else begin
            ring[slot] = distance / elapsed;
            slot       = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
            elapsed    = '0;
          end
        end
        // every pin change re-averages the whole ring
        sum = 0;
        foreach (ring[k]) sum += 64'(ring[k]);
        avg_speed = SPEED_W'(sum / RING_DEPTH);
      end
      want.speed   = avg_speed;
      want.stopped = (elapsed > timeout);
      pending.push_back(want);
    endfunction

    function void check_result(speed_result_t got);
      speed_result_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: speed=%0d too_fast=%0b stopped=%0b",
               got.speed, got.too_fast, got.stopped);
        errors++;
        return;
      end
      want = pending.pop_front();
      n_results++;
      if (got.stopped) n_stopped++;
      if (got.speed !== want.speed) begin
        $error("speed: expected %0d, got %0d", want.speed, got.speed);
        errors++;
      end
      if (got.too_fast !== want.too_fast) begin
        $error("too_fast: expected %0b, got %0b", want.too_fast, got.too_fast);
        errors++;
      end
      if (got.stopped !== want.stopped) begin
        $error("stopped: expected %0b, got %0b", want.stopped, got.stopped);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic steady = 1'b0;  // no idling on either side while set

  wspa_in_if  in_if ();
  wspa_out_if out_if ();
  wspa_cfg_if cfg_if ();

  speed_scoreboard sb = new();

  wheel_speed_period_averager dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One event beat; valid stays high after the beat unless a gap follows
  task automatic send_event(logic op, logic level, logic [TICK_W-1:0] tick);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.pin_level <= level;
    in_if.tick_ms   <= tick;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_event(op, level, tick);
  endtask

  // unused fields carry random bits
  task automatic send_tick(logic [TICK_W-1:0] ms);
    send_event(OP_TICK, 1'($urandom), ms);
  endtask

  task automatic send_pin(logic level);
    send_event(OP_PIN_CHANGE, level, TICK_W'($urandom));
  endtask

  // Stop sending and wait for every owed result beat
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back while the block is idle
  task automatic set_config(logic [SPEED_W-1:0] distance, logic [ELAPSED_W-1:0] tmo);
    logic [CFG_DATA_W-1:0] tdata;
    drain();
    tdata = {9'($urandom), tmo};  // upper bits are don't-care for the timeout
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= REG_DIST;
    cfg_if.wdata   <= distance;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(REG_DIST, distance);
    cfg_if.reg_idx <= REG_TIMEOUT;
    cfg_if.wdata   <= tdata;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(REG_TIMEOUT, tdata);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly tick runs closed by a falling then a rising edge; some noise,
  // some back-to-back falling edges
  task automatic run_traffic(int unsigned n_items, int unsigned tick_hi);
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 15) == 0) send_tick(TICK_W'($urandom_range(0, 255)));
          else send_tick(TICK_W'($urandom_range(0, tick_hi)));
        end
        send_pin(LEVEL_FALL);
        send_pin(LEVEL_RISE);
        sent += n + 2;
      end else if (kind < 9) begin
        send_event(1'($urandom), 1'($urandom), TICK_W'($urandom));
        sent++;
      end else begin
        send_pin(LEVEL_FALL);
        send_pin(LEVEL_FALL);
        sent += 2;
      end
    end
  endtask

  // Result side: random stalls on ready, check each accepted beat
  initial begin
    int unsigned   hold;
    speed_result_t got;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.speed    = out_if.speed;
        got.too_fast = out_if.too_fast;
        got.stopped  = out_if.stopped;
        sb.check_result(got);
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  // Main sequence
  initial begin
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_TICK;
    in_if.pin_level <= LEVEL_RISE;
    in_if.tick_ms   <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.reg_idx  <= REG_DIST;
    cfg_if.wdata    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values
    send_pin(LEVEL_FALL);              // falling edge straight after reset: too fast
    send_pin(LEVEL_RISE);
    send_tick(8'd0);                   // zero-length tick
    send_tick(8'd255);
    send_pin(LEVEL_FALL);
    send_tick(8'd1);
    send_pin(LEVEL_FALL);              // shortest period, full distance
    send_pin(LEVEL_RISE);
    repeat (4) send_tick(8'd255);      // passes the timeout, speed forced to zero
    send_tick(8'd0);
    send_pin(LEVEL_RISE);              // ring average comes back, still stopped
    send_pin(LEVEL_FALL);
    repeat (4) send_tick(8'd250);      // lands exactly on the timeout
    send_tick(8'd1);                   // one past it
    send_pin(LEVEL_FALL);

    // Largest distance, zero timeout: ring fills with big quotients
    set_config(25'h1FFFFFF, 16'd0);
    run_traffic(140, 3);

    // Zero distance, largest timeout
    set_config(25'd0, 16'hFFFF);
    run_traffic(80, 255);

    // Random distance, short timeout, no idling
    set_config(SPEED_W'($urandom), ELAPSED_W'($urandom_range(0, 600)));
    steady = 1'b1;
    run_traffic(220, 150);
    steady = 1'b0;

    // Elapsed counter saturation, timeout at its top
    set_config(DIST_RESET, 16'hFFFF);
    repeat (262) send_tick(8'd255);
    send_pin(LEVEL_FALL);
    send_pin(LEVEL_RISE);
    run_traffic(60, 255);

    // Everything random
    set_config(SPEED_W'($urandom), ELAPSED_W'($urandom));
    run_traffic(250, 255);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end

    $display("Run: %0d ticks and %0d pin changes (%0d too fast) over six register settings,",
             sb.n_ticks, sb.n_pins, sb.n_too_fast);
    $display("     %0d result beats compared, %0d reporting a stopped wheel.",
             sb.n_results, sb.n_stopped);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #7000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
design/wspa_pkg.sv
design/wspa_if.sv
design/wspa_div.sv
design/wspa_datapath.sv
design/wspa_ctrl.sv
design/wheel_speed_period_averager.sv
verif/tb_wheel_speed_period_averager.sv
